>>> rtl/crb_pkg.sv
package crb_pkg;

   localparam int BYTE_W    = 8;
   localparam int CRC_W     = 16;
   localparam int FRAME_LEN = 14;
   localparam int ROW_LEN   = FRAME_LEN - 1;
   localparam int STEP_W    = $clog2(ROW_LEN + 1);
   localparam int BEAT_W    = $clog2(FRAME_LEN + 1);

   localparam int LEN_POS    = 1;
   localparam int FILLER_POS = 7;
   localparam int LAST_POS   = FRAME_LEN - 1;

   localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;
   localparam logic [BYTE_W-1:0] FILLER_BYTE = 8'hFF;
   localparam logic [BYTE_W-1:0] LEN_BYTE    = 8'(FRAME_LEN);

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [FRAME_LEN-1:0][BYTE_W-1:0] frame_type;

   typedef struct packed {
      logic signed [BYTE_W-1:0] thrust_z;
      logic signed [BYTE_W-1:0] thrust_y;
      logic signed [BYTE_W-1:0] thrust_x;
      logic signed [BYTE_W-1:0] thrust_n;
      logic [BYTE_W-1:0]        ballast_cmd;
      logic [BYTE_W-1:0]        control_one;
      logic [BYTE_W-1:0]        manip_cmd;
      logic [BYTE_W-1:0]        control_two;
      logic [BYTE_W-1:0]        light_cmd;
   } cmd_type;

   typedef struct packed {
      logic      load;
      frame_type frame;
   } handoff_type;

   function automatic logic [CRC_W-1:0] crc_shift_byte(logic [CRC_W-1:0] crc,
                                                        logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] r;
      r = crc;
      for (int k = BYTE_W - 1; k >= 0; k--) begin
         r = {r[CRC_W-2:0], data[k]} ^ (r[CRC_W-1] ? CRC_POLY : '0);
      end
      return r;
   endfunction

endpackage

>>> rtl/crb_if.sv
interface crb_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] thrust_z;
   logic signed [7:0] thrust_y;
   logic signed [7:0] thrust_x;
   logic signed [7:0] thrust_n;
   logic [7:0]        ballast_cmd;
   logic [7:0]        control_one;
   logic [7:0]        manip_cmd;
   logic [7:0]        control_two;
   logic [7:0]        light_cmd;

   modport source (
      output valid, thrust_z, thrust_y, thrust_x, thrust_n, ballast_cmd,
             control_one, manip_cmd, control_two, light_cmd,
      input  ready
   );
   modport sink (
      input  valid, thrust_z, thrust_y, thrust_x, thrust_n, ballast_cmd,
             control_one, manip_cmd, control_two, light_cmd,
      output ready
   );
endinterface

interface crb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_last;

   modport source (output valid, frame_byte, frame_last, input ready);
   modport sink (input valid, frame_byte, frame_last, output ready);
endinterface

interface crb_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_id;

   modport source (output valid, frame_id, input ready);
   modport sink (input valid, frame_id, output ready);
endinterface

>>> rtl/crb_cell.sv
module crb_cell
   import crb_pkg::*;
(
   input  logic     clock,
   input  logic     load_en,
   input  byte_type load_byte,
   input  logic     shift_en,
   input  byte_type shift_byte,
   output byte_type cell_q
);

   byte_type data_ff;
   byte_type data_in;

   always_comb begin
      data_in = data_ff;
      if (load_en) begin
         data_in = load_byte;
      end else if (shift_en) begin
         data_in = shift_byte;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_q = data_ff;

endmodule

>>> rtl/crb_crc_row.sv
module crb_crc_row
   import crb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept_i,
   input  cmd_type     cmd_i,
   input  byte_type    frame_id_i,
   input  logic        out_free_i,
   output logic        ready_o,
   output handoff_type handoff_o
);

   logic [ROW_LEN-1:0][BYTE_W-1:0] load_q;
   logic [ROW_LEN-1:0][BYTE_W-1:0] row_q;

   logic              full_ff, full_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   byte_type          id_ff, id_in;
   logic              done;
   logic              step_en;
   logic              load;

   always_comb begin
      load_q     = '0;
      load_q[0]  = LEN_BYTE;
      load_q[1]  = cmd_i.thrust_z;
      load_q[2]  = cmd_i.thrust_y;
      load_q[3]  = cmd_i.thrust_x;
      load_q[4]  = cmd_i.thrust_n;
      load_q[5]  = cmd_i.ballast_cmd;
      load_q[6]  = FILLER_BYTE;
      load_q[7]  = cmd_i.control_one;
      load_q[8]  = cmd_i.manip_cmd;
      load_q[9]  = cmd_i.control_two;
      load_q[10] = cmd_i.light_cmd;
   end

   assign done    = full_ff && (step_ff == STEP_W'(ROW_LEN));
   assign step_en = full_ff && !done;
   assign load    = done && out_free_i;
   assign ready_o = !full_ff || load;

   // rotate the row once around: data bytes, then the two zero bytes, through the CRC
   for (genvar i = 0; i < ROW_LEN; i++) begin : g_cell
      crb_cell u_cell (
         .clock      (clock),
         .load_en    (accept_i),
         .load_byte  (load_q[i]),
         .shift_en   (step_en),
         .shift_byte (row_q[(i + 1) % ROW_LEN]),
         .cell_q     (row_q[i])
      );
   end

   always_comb begin
      full_in = full_ff;
      step_in = step_ff;
      crc_in  = crc_ff;
      id_in   = id_ff;
      if (accept_i) begin
         full_in = 1'b1;
         step_in = '0;
         crc_in  = crc_shift_byte(CRC_INIT, frame_id_i);
         id_in   = frame_id_i;
      end else if (step_en) begin
         step_in = step_ff + 1'b1;
         crc_in  = crc_shift_byte(crc_ff, row_q[0]);
      end else if (load) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         full_ff <= full_in;
         step_ff <= step_in;
      end
      crc_ff <= crc_in;
      id_ff  <= id_in;
   end

   always_comb begin
      handoff_o.load     = load;
      handoff_o.frame    = '0;
      handoff_o.frame[0] = id_ff;
      for (int i = 1; i < FRAME_LEN - 2; i++) begin
         handoff_o.frame[i] = row_q[i-1];
      end
      handoff_o.frame[FRAME_LEN-2] = crc_ff[CRC_W-1:BYTE_W];
      handoff_o.frame[FRAME_LEN-1] = crc_ff[BYTE_W-1:0];
   end

endmodule

>>> rtl/crb_out_row.sv
module crb_out_row
   import crb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  handoff_type handoff_i,
   input  logic        out_ready_i,
   output logic        out_free_o,
   output logic        out_valid_o,
   output byte_type    out_byte_o,
   output logic        out_last_o
);

   logic [FRAME_LEN-1:0][BYTE_W-1:0] row_q;
   logic [BEAT_W-1:0]                left_ff, left_in;
   logic                             advance;

   assign out_valid_o = (left_ff != '0);
   assign out_last_o  = (left_ff == BEAT_W'(1));
   assign out_byte_o  = row_q[0];
   assign advance     = out_valid_o && out_ready_i;
   assign out_free_o  = !out_valid_o || (out_last_o && out_ready_i);

   for (genvar i = 0; i < FRAME_LEN; i++) begin : g_cell
      crb_cell u_cell (
         .clock      (clock),
         .load_en    (handoff_i.load),
         .load_byte  (handoff_i.frame[i]),
         .shift_en   (advance),
         .shift_byte ((i == FRAME_LEN - 1) ? byte_type'(0) : row_q[(i + 1) % FRAME_LEN]),
         .cell_q     (row_q[i])
      );
   end

   always_comb begin
      left_in = left_ff;
      if (handoff_i.load) begin
         left_in = BEAT_W'(FRAME_LEN);
      end else if (advance) begin
         left_in = left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

endmodule

>>> rtl/command_frame_crc_builder_top.sv
// A command is rotated through the CRC in the CRC row and then handed to the output row,
// which offers the frame bytes in order, the last one marked.
// The 14-byte output row sends one byte per cycle while the output side is ready; the
// 13-step CRC rotation of the next command overlaps it.
// Reset (synchronous, active high) empties both rows and sets the frame id to 0.
module command_frame_crc_builder_top
   import crb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   crb_req_if.sink  req_chan,
   crb_rsp_if.source rsp_chan,
   crb_csr_if.sink  csr_chan
);

   byte_type    frame_id_ff;
   byte_type    frame_id_in;
   cmd_type     cmd;
   handoff_type handoff;
   logic        req_ready;
   logic        out_free;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      frame_id_in = frame_id_ff;
      if (csr_chan.valid) begin
         frame_id_in = csr_chan.frame_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_id_ff <= '0;
      end else begin
         frame_id_ff <= frame_id_in;
      end
   end

   always_comb begin
      cmd.thrust_z    = req_chan.thrust_z;
      cmd.thrust_y    = req_chan.thrust_y;
      cmd.thrust_x    = req_chan.thrust_x;
      cmd.thrust_n    = req_chan.thrust_n;
      cmd.ballast_cmd = req_chan.ballast_cmd;
      cmd.control_one = req_chan.control_one;
      cmd.manip_cmd   = req_chan.manip_cmd;
      cmd.control_two = req_chan.control_two;
      cmd.light_cmd   = req_chan.light_cmd;
   end

   assign req_chan.ready = req_ready;

   crb_crc_row u_crc_row (
      .clock      (clock),
      .reset      (reset),
      .accept_i   (req_chan.valid && req_ready),
      .cmd_i      (cmd),
      .frame_id_i (frame_id_ff),
      .out_free_i (out_free),
      .ready_o    (req_ready),
      .handoff_o  (handoff)
   );

   crb_out_row u_out_row (
      .clock       (clock),
      .reset       (reset),
      .handoff_i   (handoff),
      .out_ready_i (rsp_chan.ready),
      .out_free_o  (out_free),
      .out_valid_o (rsp_chan.valid),
      .out_byte_o  (rsp_chan.frame_byte),
      .out_last_o  (rsp_chan.frame_last)
   );

endmodule

>>> rtl/crb_checker.sv
module crb_checker
   import crb_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input byte_type rsp_byte,
   input logic     rsp_last
);

   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic [1:0]        pending_ff, pending_in;
   logic              req_acc;
   logic              rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      beat_in    = beat_ff;
      pending_in = pending_ff;
      if (rsp_acc) begin
         beat_in = rsp_last ? '0 : beat_ff + 1'b1;
      end
      if (req_acc && !(rsp_acc && rsp_last)) begin
         pending_in = pending_ff + 1'b1;
      end else if (!req_acc && rsp_acc && rsp_last) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff    <= '0;
         pending_ff <= '0;
      end else begin
         beat_ff    <= beat_in;
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_last))
      else $error("stalled transaction changed");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> (rsp_last == (beat_ff == BEAT_W'(LAST_POS))))
      else $error("frame_last out of place");

   a_fixed_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> ((beat_ff != BEAT_W'(LEN_POS)) || (rsp_byte == LEN_BYTE))
                  && ((beat_ff != BEAT_W'(FILLER_POS)) || (rsp_byte == FILLER_BYTE)))
      else $error("length or filler byte wrong");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 2'd0))
      else $error("transaction offered without a command");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two commands in flight");

endmodule

bind command_frame_crc_builder_top crb_checker u_crb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_byte  (rsp_chan.frame_byte),
   .rsp_last  (rsp_chan.frame_last)
);

>>> dv/tb_command_frame_crc_builder_top.sv
`timescale 1ns / 1ps

module tb_command_frame_crc_builder_top;
   import crb_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD  = 300;
   localparam int END_WAIT   = 40;

   typedef struct {
      byte_type data;
      logic     last;
   } beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   crb_req_if req_if ();
   crb_rsp_if rsp_if ();
   crb_csr_if csr_if ();

   command_frame_crc_builder_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   cmd_type  cmds_to_send[$];
   beat_type frame_bytes_due[$];
   byte_type frame_id_shadow = '0;

   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   bit sender_hold       = 1'b0;
   bit long_hold_go      = 1'b0;
   int hold_count        = 0;
   int errors            = 0;
   int cmds_accepted     = 0;
   int bytes_checked     = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void predict_frame_bytes(cmd_type c);
      byte_type         f [FRAME_LEN];
      logic [CRC_W-1:0] crc;
      byte_type         d;
      logic             top_bit;
      f[0]          = frame_id_shadow;
      f[LEN_POS]    = 8'(FRAME_LEN);
      f[2]          = c.thrust_z;
      f[3]          = c.thrust_y;
      f[4]          = c.thrust_x;
      f[5]          = c.thrust_n;
      f[6]          = c.ballast_cmd;
      f[FILLER_POS] = 8'hFF;
      f[8]          = c.control_one;
      f[9]          = c.manip_cmd;
      f[10]         = c.control_two;
      f[11]         = c.light_cmd;
      // augmented form: payload bytes, then two zero bytes flush the register
      crc = 16'hFFFF;
      for (int i = 0; i < FRAME_LEN; i++) begin
         d = (i < FRAME_LEN - 2) ? f[i] : 8'h00;
         for (int b = BYTE_W - 1; b >= 0; b--) begin
            top_bit = crc[CRC_W-1];
            crc     = {crc[CRC_W-2:0], d[b]};
            if (top_bit) begin
               crc = crc ^ 16'h1021;
            end
         end
      end
      f[FRAME_LEN-2] = crc[15:8];
      f[LAST_POS]    = crc[7:0];
      for (int i = 0; i < FRAME_LEN; i++) begin
         frame_bytes_due.push_back('{data: f[i], last: (i == LAST_POS)});
      end
   endfunction

   function automatic cmd_type make_cmd(byte_type z, byte_type y, byte_type x, byte_type n,
                                        byte_type bal, byte_type c1, byte_type man,
                                        byte_type c2, byte_type lgt);
      cmd_type c;
      c.thrust_z    = z;
      c.thrust_y    = y;
      c.thrust_x    = x;
      c.thrust_n    = n;
      c.ballast_cmd = bal;
      c.control_one = c1;
      c.manip_cmd   = man;
      c.control_two = c2;
      c.light_cmd   = lgt;
      return c;
   endfunction

   function automatic byte_type rand_field();
      case ($urandom_range(15))
         0: return 8'h00;
         1: return 8'h7F;
         2: return 8'h80;
         3: return 8'hFF;
         default: return byte_type'($urandom);
      endcase
   endfunction

   task automatic queue_random_cmds(int count);
      repeat (count) begin
         cmds_to_send.push_back(make_cmd(rand_field(), rand_field(), rand_field(),
                                         rand_field(), rand_field(), rand_field(),
                                         rand_field(), rand_field(), rand_field()));
      end
   endtask

   task automatic queue_directed_cmds();
      cmds_to_send.push_back(make_cmd(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                      8'h00, 8'h00));
      cmds_to_send.push_back(make_cmd(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                      8'hFF, 8'hFF));
      cmds_to_send.push_back(make_cmd(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h00, 8'h00, 8'h00,
                                      8'h00, 8'h00));
      cmds_to_send.push_back(make_cmd(8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hFF, 8'hFF,
                                      8'hFF, 8'hFF));
      cmds_to_send.push_back(make_cmd(8'h80, 8'h7F, 8'hFF, 8'h01, 8'hAA, 8'h55, 8'hAA,
                                      8'h55, 8'hAA));
      cmds_to_send.push_back(make_cmd(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
                                      8'hAA, 8'h55));
   endtask

   // hold until input backlog, input channel and result store are all empty
   task automatic drain_all();
      do @(negedge clock);
      while (cmds_to_send.size() != 0 || req_if.valid || frame_bytes_due.size() != 0);
   endtask

   task automatic write_frame_id(byte_type value);
      @(posedge clock);
      csr_if.valid    <= 1'b1;
      csr_if.frame_id <= value;
      do @(posedge clock);
      while (!csr_if.ready);
      csr_if.valid    <= 1'b0;
      frame_id_shadow  = value;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_frame_bytes(cmds_to_send.pop_front());
            cmds_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (cmds_to_send.size() != 0 && !sender_hold &&
                $urandom_range(99) >= sender_idle_pct) begin
               req_if.valid       <= 1'b1;
               req_if.thrust_z    <= cmds_to_send[0].thrust_z;
               req_if.thrust_y    <= cmds_to_send[0].thrust_y;
               req_if.thrust_x    <= cmds_to_send[0].thrust_x;
               req_if.thrust_n    <= cmds_to_send[0].thrust_n;
               req_if.ballast_cmd <= cmds_to_send[0].ballast_cmd;
               req_if.control_one <= cmds_to_send[0].control_one;
               req_if.manip_cmd   <= cmds_to_send[0].manip_cmd;
               req_if.control_two <= cmds_to_send[0].control_two;
               req_if.light_cmd   <= cmds_to_send[0].light_cmd;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      beat_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_count    = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (frame_bytes_due.size() == 0) begin
               $display("%0t: unexpected frame byte: expected none, got %02h last %0b",
                        $time, rsp_if.frame_byte, rsp_if.frame_last);
               errors++;
            end else begin
               want = frame_bytes_due.pop_front();
               bytes_checked++;
               if (rsp_if.frame_byte !== want.data || rsp_if.frame_last !== want.last) begin
                  $display("%0t: frame byte mismatch: expected %02h last %0b, got %02h last %0b",
                           $time, want.data, want.last, rsp_if.frame_byte,
                           rsp_if.frame_last);
                  errors++;
               end
            end
         end
         if (long_hold_go && hold_count < LONG_HOLD) begin
            hold_count++;
            rsp_if.ready <= 1'b0;
         end else begin
            if (!long_hold_go) begin
               hold_count = 0;
            end
            rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      req_if.valid       = 1'b0;
      req_if.thrust_z    = '0;
      req_if.thrust_y    = '0;
      req_if.thrust_x    = '0;
      req_if.thrust_n    = '0;
      req_if.ballast_cmd = '0;
      req_if.control_one = '0;
      req_if.manip_cmd   = '0;
      req_if.control_two = '0;
      req_if.light_cmd   = '0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.frame_id    = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct   = 19;
      receiver_idle_pct = 64;
      @(negedge clock);
      queue_directed_cmds();
      drain_all();
      write_frame_id(8'hFF);
      queue_directed_cmds();
      drain_all();

      // stall the output long enough for the block to back up its input
      write_frame_id(byte_type'($urandom));
      queue_random_cmds(80);
      long_hold_go = 1'b1;
      while (hold_count < LONG_HOLD) @(negedge clock);
      long_hold_go = 1'b0;
      drain_all();

      sender_idle_pct   = 64;
      receiver_idle_pct = 19;
      write_frame_id(8'h00);
      queue_random_cmds(40);
      while (cmds_to_send.size() > 20) @(negedge clock);
      sender_hold = 1'b1;
      do @(negedge clock);
      while (req_if.valid || frame_bytes_due.size() != 0);
      sender_hold = 1'b0;
      queue_random_cmds(40);
      drain_all();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_frame_id(byte_type'($urandom));
      queue_random_cmds(90);
      drain_all();

      repeat (END_WAIT) @(posedge clock);
      errors += frame_bytes_due.size();
      $display("Checked %0d commands, %0d frame bytes, frame ids 0, 255 and random values.",
               cmds_accepted, bytes_checked);
      $display("Idle mixes 19/64, 64/19 and none, plus a long output stall and a sender pause.");
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
